@@ hw/rtl/f2c_pkg.sv @@
package f2c_pkg;

    localparam int DEF_MAX_WAYPOINTS = 256;
    localparam int ROOT_STEPS        = 32;
    localparam int DIV_STEPS         = 32;
    localparam int MUL_STEPS         = 6;
    localparam int SQR_STEPS         = 3;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30  = 64'd1 << 29;
    localparam logic [63:0] ROOT_TOP  = 64'd1 << 62;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_START,
        ST_RD_END,
        ST_DIFF,
        ST_SQR,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_SCAN,
        RD_START,
        RD_END
    } t_rd_sel;

    typedef enum logic [2:0] {
        MS_DXDX,
        MS_DYDY,
        MS_GCX,
        MS_DCY,
        MS_GCY,
        MS_DCX
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic     accept;
        t_rd_sel  rd_sel;
        logic     scan_step;
        logic     lat_start;
        logic     lat_diff;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_sel_y;
        logic     div_step;
        logic     lat_cx;
        logic     lat_cy;
        logic     lat_px;
        logic     lat_py;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_more;
        logic degen_now;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/f2c_ctrl.sv @@
module f2c_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_kind,
    output logic            o_stall,
    input  f2c_pkg::t_status i_status,
    output f2c_pkg::t_cmd    o_cmd
);
    import f2c_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.rd_sel = RD_ZERO;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind) n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_sel    = RD_SCAN;
                o_cmd.scan_step = 1'b1;
                if (!i_status.scan_more) n_state = ST_RD_START;
            end
            ST_RD_START: begin
                o_cmd.rd_sel = RD_START;
                n_state      = ST_RD_END;
            end
            ST_RD_END: begin
                o_cmd.rd_sel    = RD_END;
                o_cmd.lat_start = 1'b1;
                n_state         = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.lat_diff = 1'b1;
                n_step         = '0;
                n_state        = i_status.degen_now ? ST_OUT : ST_SQR;
            end
            ST_SQR: begin
                n_step = r_step + 6'd1;
                case (r_step)
                    6'd0: o_cmd.mul_sel = MS_DXDX;
                    6'd1: begin
                        o_cmd.mul_sel = MS_DYDY;
                        o_cmd.acc_op  = ACC_LOAD;
                    end
                    default: begin
                        o_cmd.acc_op = ACC_ADD;
                        n_step       = '0;
                        n_state      = ST_SQRT;
                    end
                endcase
            end
            ST_SQRT: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'd0) o_cmd.sqrt_init = 1'b1;
                else o_cmd.sqrt_step = 1'b1;
                if (r_step == 6'(ROOT_STEPS)) begin
                    n_step  = '0;
                    n_state = ST_DIVX;
                end
            end
            ST_DIVX, ST_DIVY: begin
                o_cmd.div_sel_y = (r_state == ST_DIVY);
                n_step = r_step + 6'd1;
                if (r_step == 6'd0) o_cmd.div_init = 1'b1;
                else if (r_step <= 6'(DIV_STEPS)) o_cmd.div_step = 1'b1;
                else begin
                    o_cmd.lat_cx = (r_state == ST_DIVX);
                    o_cmd.lat_cy = (r_state == ST_DIVY);
                    n_step       = '0;
                    n_state      = (r_state == ST_DIVX) ? ST_DIVY : ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 6'd1;
                case (r_step)
                    6'd0: o_cmd.mul_sel = MS_GCX;
                    6'd1: begin
                        o_cmd.mul_sel = MS_DCY;
                        o_cmd.acc_op  = ACC_LOAD;
                    end
                    6'd2: begin
                        o_cmd.mul_sel = MS_GCY;
                        o_cmd.acc_op  = ACC_ADD;
                    end
                    6'd3: begin
                        // x sum is complete, start the y sum
                        o_cmd.mul_sel = MS_DCX;
                        o_cmd.acc_op  = ACC_LOAD;
                        o_cmd.lat_px  = 1'b1;
                    end
                    6'd4: o_cmd.acc_op = ACC_SUB;
                    default: begin
                        o_cmd.lat_py = 1'b1;
                        n_step       = '0;
                        n_state      = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/f2c_dp.sv @@
module f2c_dp #(
    parameter int MAX_WAYPOINTS = f2c_pkg::DEF_MAX_WAYPOINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  f2c_pkg::t_cmd       i_cmd,
    output f2c_pkg::t_status    o_status,
    input  logic               i_cfg_valid,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_kind,
    input  logic [7:0]         i_entry_index,
    input  logic signed [31:0] i_entry_x,
    input  logic signed [31:0] i_entry_y,
    input  logic [30:0]        i_entry_s,
    input  logic [30:0]        i_query_s,
    input  logic signed [31:0] i_offset_d,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_degenerate
);
    import f2c_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int NW = $clog2(MAX_WAYPOINTS + 1);

    function automatic logic signed [31:0] round_add(input logic signed [63:0] acc,
                                                     input logic signed [31:0] base);
        logic [63:0]        mag;
        logic [33:0]        q;
        logic signed [34:0] rv;
        logic signed [34:0] sum;
        mag = acc[63] ? (64'd0 - acc) : acc;
        q   = 34'((mag + HALF_Q30) >> 30);
        rv  = acc[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum = rv + 35'(base);
        if (sum > 35'sd2147483647) round_add = 32'sh7fffffff;
        else if (sum < -35'sd2147483648) round_add = 32'sh80000000;
        else round_add = sum[31:0];
    endfunction

    logic signed [31:0] mem_x [MAX_WAYPOINTS];
    logic signed [31:0] mem_y [MAX_WAYPOINTS];
    logic [30:0]        mem_s [MAX_WAYPOINTS];

    logic [8:0]         r_count;
    logic [NW-1:0]      n_eff;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] r_rd_x, r_rd_y;
    logic [30:0]        r_rd_s;

    logic [30:0]        r_q;
    logic signed [31:0] r_d;
    logic [NW-1:0]      r_idx;
    logic [AW-1:0]      r_start;
    logic [NW-1:0]      start_p1;
    logic [AW-1:0]      end_idx;
    logic               scan_cond;

    logic signed [31:0] r_x0, r_y0;
    logic [30:0]        r_s0;
    logic signed [32:0] dx33, dy33, dxh, dyh;
    logic               big;
    logic signed [31:0] r_dx, r_dy, r_g;
    logic               r_degen;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_c, r_prod, r_acc;

    logic [63:0]        r_sv, r_sr, r_sbit, root_t;
    logic [31:0]        den;

    logic signed [31:0] div_src;
    logic [31:0]        div_mag;
    logic [63:0]        num;
    logic [31:0]        r_rem, r_qw, qc;
    logic [32:0]        div_t;
    logic               r_neg;
    logic signed [31:0] r_cx, r_cy, unit_c;
    logic signed [31:0] r_px, r_py;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 9'd1;
        else if (i_cfg_valid) r_count <= i_cfg_data;
    end

    always_comb begin
        if (r_count == 9'd0) n_eff = NW'(1);
        else if (32'(r_count) > MAX_WAYPOINTS) n_eff = NW'(MAX_WAYPOINTS);
        else n_eff = NW'(r_count);
    end

    // table memory
    assign start_p1 = NW'(r_start) + NW'(1);
    assign end_idx  = (start_p1 >= n_eff) ? '0 : AW'(start_p1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN:  rd_addr = AW'(r_idx) + AW'(1);
            RD_START: rd_addr = r_start;
            RD_END:   rd_addr = end_idx;
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_kind && (32'(i_entry_index) < MAX_WAYPOINTS)) begin
            mem_x[AW'(i_entry_index)] <= i_entry_x;
            mem_y[AW'(i_entry_index)] <= i_entry_y;
            mem_s[AW'(i_entry_index)] <= i_entry_s;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
        r_rd_s <= mem_s[rd_addr];
    end

    // segment search, one entry a cycle with the next read in flight
    assign scan_cond = (r_idx < n_eff) && (r_q > r_rd_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_start <= '0;
        end else if (i_cmd.accept && i_kind) begin
            r_idx   <= '0;
            r_start <= '0;
        end else if (i_cmd.scan_step && scan_cond) begin
            r_start <= AW'(r_idx);
            r_idx   <= r_idx + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_kind) begin
            r_q <= i_query_s;
            r_d <= i_offset_d;
        end
    end

    // segment vector
    assign dx33 = {r_rd_x[31], r_rd_x} - {r_x0[31], r_x0};
    assign dy33 = {r_rd_y[31], r_rd_y} - {r_y0[31], r_y0};
    assign big  = (dx33 > 33'sd2147483647) || (dx33 < -33'sd2147483647) ||
                  (dy33 > 33'sd2147483647) || (dy33 < -33'sd2147483647);
    // halve toward zero
    assign dxh  = (dx33 + $signed({32'd0, dx33[32]})) >>> 1;
    assign dyh  = (dy33 + $signed({32'd0, dy33[32]})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_start) begin
            r_x0 <= r_rd_x;
            r_y0 <= r_rd_y;
            r_s0 <= r_rd_s;
        end
        if (i_cmd.lat_diff) begin
            r_dx    <= big ? dxh[31:0] : dx33[31:0];
            r_dy    <= big ? dyh[31:0] : dy33[31:0];
            r_degen <= (dx33 == 33'sd0) && (dy33 == 33'sd0);
            r_g     <= $signed({1'b0, r_q}) - $signed({1'b0, r_s0});
        end
    end

    // shared multiplier and accumulator
    always_comb begin
        case (i_cmd.mul_sel)
            MS_DXDX: begin mul_a = r_dx; mul_b = r_dx; end
            MS_DYDY: begin mul_a = r_dy; mul_b = r_dy; end
            MS_GCX:  begin mul_a = r_g;  mul_b = r_cx; end
            MS_DCY:  begin mul_a = r_d;  mul_b = r_cy; end
            MS_GCY:  begin mul_a = r_g;  mul_b = r_cy; end
            default: begin mul_a = r_d;  mul_b = r_cx; end
        endcase
    end
    assign prod_c = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    // bit-serial square root
    assign root_t = r_sr + r_sbit;
    assign den    = (r_sr[31:0] == 32'd0) ? 32'd1 : r_sr[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sv   <= r_acc;
            r_sr   <= '0;
            r_sbit <= ROOT_TOP;
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= root_t) begin
                r_sv <= r_sv - root_t;
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // restoring divider, quotient known to fit 32 bits
    assign div_src = i_cmd.div_sel_y ? r_dy : r_dx;
    assign div_mag = div_src[31] ? (32'd0 - div_src) : div_src;
    assign num     = {3'd0, div_mag[30:0], 30'd0} + {33'd0, den[31:1]};
    assign div_t   = {r_rem, r_qw[31]};
    assign qc      = (64'(r_qw) > ONE_Q30) ? ONE_Q30[31:0] : r_qw;
    assign unit_c  = r_neg ? -$signed(qc) : $signed(qc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= num[63:32];
            r_qw  <= num[31:0];
            r_neg <= div_src[31];
        end else if (i_cmd.div_step) begin
            if (div_t >= {1'b0, den}) begin
                r_rem <= 32'(div_t - {1'b0, den});
                r_qw  <= {r_qw[30:0], 1'b1};
            end else begin
                r_rem <= div_t[31:0];
                r_qw  <= {r_qw[30:0], 1'b0};
            end
        end
        if (i_cmd.lat_cx) r_cx <= unit_c;
        if (i_cmd.lat_cy) r_cy <= unit_c;
        if (i_cmd.lat_px) r_px <= round_add(r_acc, r_x0);
        if (i_cmd.lat_py) r_py <= round_add(r_acc, r_y0);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_point_x    <= r_degen ? r_x0 : r_px;
            o_point_y    <= r_degen ? r_y0 : r_py;
            o_degenerate <= r_degen;
        end
    end

    assign o_status.scan_more = scan_cond;
    assign o_status.degen_now = (dx33 == 33'sd0) && (dy33 == 33'sd0);
    assign o_status.out_free  = !o_valid || !i_stall;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_valid)
        else $error("result load did not raise valid");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_idx <= n_eff))
        else $error("scan index ran past waypoint count");
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lat_cx |=> (r_cx <= 32'sd1073741824) && (r_cx >= -32'sd1073741824))
        else $error("unit vector out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !i_cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

@@ hw/rtl/frenet_to_cartesian.sv @@
// Frenet to Cartesian conversion over a waypoint table of up to MAX_WAYPOINTS
// entries. A load item writes one table slot when its index is in range and
// gives no result. A query item first scans forward over k entries (k is at
// most the waypoint count), reading the table memory one entry per cycle;
// then a one-bit-per-cycle square root and two restoring divisions form the
// unit vector, and a shared multiplier builds both coordinates. A query whose
// segment has zero length skips that arithmetic and finishes once the segment
// ends are read. One item is worked on at a time; the finished result sits in
// an output register so the next item can be taken while it waits.
module frenet_to_cartesian #(
    parameter int MAX_WAYPOINTS = f2c_pkg::DEF_MAX_WAYPOINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [8:0]         i_cfg_data,
    output logic               o_cfg_ready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [7:0]         i_entry_index,
    input  logic signed [31:0] i_entry_x,
    input  logic signed [31:0] i_entry_y,
    input  logic [30:0]        i_entry_s,
    input  logic [30:0]        i_query_s,
    input  logic signed [31:0] i_offset_d,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_degenerate
);
    import f2c_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    f2c_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    f2c_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_entry_x     (i_entry_x),
        .i_entry_y     (i_entry_y),
        .i_entry_s     (i_entry_s),
        .i_query_s     (i_query_s),
        .i_offset_d    (i_offset_d),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_degenerate  (o_degenerate)
    );

endmodule
